FILE: hdl/max_heap_priority_queue_assert.svh
// assertion macros for the max heap priority queue
`ifndef MAX_HEAP_PRIORITY_QUEUE_ASSERT_SVH
`define MAX_HEAP_PRIORITY_QUEUE_ASSERT_SVH

// condition implies consequence in the same cycle
`define MHPQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// condition implies consequence in the next cycle
`define MHPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/mhpq_pkg.sv
// shared types and codes of the max heap priority queue
`default_nettype none

package mhpq_pkg;

  localparam int KEY_FIELD_W   = 32;
  localparam int STATUS_W      = 2;
  localparam int COUNT_FIELD_W = 8;

  typedef logic                          mode_t;
  typedef logic signed [KEY_FIELD_W-1:0] key_field_t;
  typedef logic [STATUS_W-1:0]           status_t;
  typedef logic [COUNT_FIELD_W-1:0]      count_field_t;

  // beat opcodes
  localparam mode_t MODE_INSERT = 1'b0;
  localparam mode_t MODE_REMOVE = 1'b1;

  // result status codes
  localparam status_t STAT_OK    = 2'd0;
  localparam status_t STAT_EMPTY = 2'd1;
  localparam status_t STAT_FULL  = 2'd2;

endpackage

`default_nettype wire

FILE: hdl/mhpq_if.sv
// valid/ready channel interfaces for requests and results
`default_nettype none

interface mhpq_in_if import mhpq_pkg::*; ();
  logic       valid;
  logic       ready;
  mode_t      mode;
  key_field_t key_value;

  modport source (output valid, output mode, output key_value, input ready);
  modport sink   (input valid, input mode, input key_value, output ready);
endinterface

interface mhpq_out_if import mhpq_pkg::*; ();
  logic         valid;
  logic         ready;
  key_field_t   removed_key;
  status_t      status;
  count_field_t entry_count;

  modport source (output valid, output removed_key, output status, output entry_count,
                  input ready);
  modport sink   (input valid, input removed_key, input status, input entry_count,
                  output ready);
endinterface

`default_nettype wire

FILE: hdl/max_heap_priority_queue.sv
// top level of the binary max heap priority queue
//
//  channel  dir  handshake     payload
//  in_if    in   valid/ready   mode, key_value
//  out_if   out  valid/ready   removed_key, status, entry_count
//
// one request at a time; the heap walk advances one tree level per cycle
// through the two-read, one-write key memory (read data registered)
// insert: written straight to the root of an empty heap; else one compare step per level climbed
// remove: one compare step per level descended; no descent with two keys or less
// full/empty requests skip the walk; no clearing pass after reset, in_if ready low in reset
// a result waits in the output register; a stalled out_if holds the walk
// only at its last step, after all memory writes are done
`default_nettype none

module max_heap_priority_queue import mhpq_pkg::*; #(
  parameter int CAPACITY  = 128,
  parameter int KEY_WIDTH = 32
) (
  input wire logic  clk,
  input wire logic  rst_n,
  mhpq_in_if.sink   in_if,
  mhpq_out_if.source out_if
);

  `include "max_heap_priority_queue_assert.svh"

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam int KW = KEY_WIDTH;

  localparam logic [CW:0] CAP_Z = (CW + 1)'(CAPACITY);
  localparam logic [CW:0] ONE_Z = (CW + 1)'(1);
  localparam logic [CW:0] TWO_Z = (CW + 1)'(2);
  localparam logic [CW:0] THR_Z = (CW + 1)'(3);

  // controller states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_UP_CMP = 3'd1;
  localparam logic [2:0] S_RM_CMP = 3'd2;
  localparam logic [2:0] S_DN_CMP = 3'd3;
  localparam logic [2:0] S_WR_FIN = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  // heap slot number to memory address
  function automatic logic [AW-1:0] slot_addr(input logic [CW:0] slot);
    logic [CW:0] d;
    d = slot - ONE_Z;
    return d[AW-1:0];
  endfunction

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic [KW-1:0] cur_r, cur_nxt;
  logic          rc_ok_r, rc_ok_nxt;
  logic [KW-1:0] res_key_r, res_key_nxt;
  status_t       res_stat_r, res_stat_nxt;

  logic          out_valid_r;
  key_field_t    out_key_r;
  status_t       out_stat_r;
  count_field_t  out_cnt_r;

  logic          we;
  logic [AW-1:0] waddr, ra0, ra1;
  logic [KW-1:0] wdata, rd0, rd1;

  logic          in_fire, can_emit, out_load;
  logic [KW+31:0] key_ext;
  logic [KW-1:0] key_in;
  logic [CW:0]   count_z, pos_z, new_slot, parent, lc, child, nlc, nrc, cnt_dec_z;
  logic [CW-1:0] cnt_dec;
  logic          take_l, take_r;
  logic [KW-1:0] best_val, child_val;
  logic [KW+31:0] res_key_ext;
  logic [CW+7:0] cnt_ext;

  mhpq_store #(
    .DEPTH (CAPACITY),
    .WIDTH (KW),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (ra0),
    .raddr_b (ra1),
    .rdata_a (rd0),
    .rdata_b (rd1)
  );

  // handshake
  assign in_if.ready = rst_n && (state_r == S_IDLE);
  assign in_fire     = in_if.valid && in_if.ready;
  assign can_emit    = !out_valid_r || out_if.ready;
  assign out_load    = (state_r == S_DONE) && can_emit;

  // key from the beat, resized to the stored width with sign
  assign key_ext = {{KW{in_if.key_value[KEY_FIELD_W-1]}}, in_if.key_value};
  assign key_in  = key_ext[KW-1:0];

  // tree index arithmetic
  assign count_z   = {1'b0, count_r};
  assign pos_z     = {1'b0, pos_r};
  assign new_slot  = count_z + ONE_Z;
  assign parent    = {2'b00, pos_r[CW-1:1]};
  assign lc        = {pos_r, 1'b0};
  assign cnt_dec_z = count_z - ONE_Z;
  assign cnt_dec   = cnt_dec_z[CW-1:0];

  // sift-down child choice, left wins a tie
  assign take_l    = $signed(rd0) > $signed(cur_r);
  assign best_val  = take_l ? rd0 : cur_r;
  assign take_r    = rc_ok_r && ($signed(rd1) > $signed(best_val));
  assign child     = take_r ? (lc + ONE_Z) : lc;
  assign child_val = take_r ? rd1 : rd0;
  assign nlc       = {child[CW-1:0], 1'b0};
  assign nrc       = nlc + ONE_Z;

  // controller
  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    pos_nxt      = pos_r;
    cur_nxt      = cur_r;
    rc_ok_nxt    = rc_ok_r;
    res_key_nxt  = res_key_r;
    res_stat_nxt = res_stat_r;
    we           = 1'b0;
    waddr        = slot_addr(pos_z);
    wdata        = cur_r;
    ra0          = slot_addr(ONE_Z);
    ra1          = slot_addr(ONE_Z);
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          res_key_nxt  = '0;
          res_stat_nxt = STAT_OK;
          if (in_if.mode == MODE_INSERT) begin
            if (count_z == CAP_Z) begin
              res_stat_nxt = STAT_FULL;
              state_nxt    = S_DONE;
            end else begin
              count_nxt = new_slot[CW-1:0];
              pos_nxt   = new_slot[CW-1:0];
              cur_nxt   = key_in;
              if (count_z == '0) begin
                we        = 1'b1;
                waddr     = slot_addr(ONE_Z);
                wdata     = key_in;
                state_nxt = S_DONE;
              end else begin
                ra0       = slot_addr({1'b0, new_slot[CW:1]});
                state_nxt = S_UP_CMP;
              end
            end
          end else begin
            if (count_z == '0) begin
              res_stat_nxt = STAT_EMPTY;
              state_nxt    = S_DONE;
            end else begin
              ra0       = slot_addr(ONE_Z);
              ra1       = slot_addr(count_z);
              state_nxt = S_RM_CMP;
            end
          end
        end
      end
      S_UP_CMP: begin
        we    = 1'b1;
        waddr = slot_addr(pos_z);
        if ($signed(rd0) < $signed(cur_r)) begin
          // parent moves down, hole moves up
          wdata   = rd0;
          pos_nxt = parent[CW-1:0];
          if (parent == ONE_Z) begin
            state_nxt = S_WR_FIN;
          end else begin
            ra0 = slot_addr({1'b0, parent[CW:1]});
          end
        end else begin
          wdata     = cur_r;
          state_nxt = S_DONE;
        end
      end
      S_RM_CMP: begin
        res_key_nxt = rd0;
        cur_nxt     = rd1;
        count_nxt   = cnt_dec;
        pos_nxt     = ONE_Z[CW-1:0];
        if (count_z == ONE_Z) begin
          state_nxt = S_DONE;
        end else if (TWO_Z > cnt_dec_z) begin
          we        = 1'b1;
          waddr     = slot_addr(ONE_Z);
          wdata     = rd1;
          state_nxt = S_DONE;
        end else begin
          ra0       = slot_addr(TWO_Z);
          ra1       = (THR_Z <= cnt_dec_z) ? slot_addr(THR_Z) : slot_addr(TWO_Z);
          rc_ok_nxt = (THR_Z <= cnt_dec_z);
          state_nxt = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        we    = 1'b1;
        waddr = slot_addr(pos_z);
        if (take_l || take_r) begin
          // larger child moves up, hole moves down
          wdata   = child_val;
          pos_nxt = child[CW-1:0];
          if (nlc > count_z) begin
            state_nxt = S_WR_FIN;
          end else begin
            ra0       = slot_addr(nlc);
            ra1       = (nrc <= count_z) ? slot_addr(nrc) : slot_addr(nlc);
            rc_ok_nxt = (nrc <= count_z);
          end
        end else begin
          wdata     = cur_r;
          state_nxt = S_DONE;
        end
      end
      S_WR_FIN: begin
        we        = 1'b1;
        waddr     = slot_addr(pos_z);
        wdata     = cur_r;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (can_emit) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // walk and result registers
  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    cur_r      <= cur_nxt;
    rc_ok_r    <= rc_ok_nxt;
    res_key_r  <= res_key_nxt;
    res_stat_r <= res_stat_nxt;
  end

  // output register
  assign res_key_ext = {{32{res_key_r[KW-1]}}, res_key_r};
  assign cnt_ext     = {8'b0, count_r};

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_key_r  <= res_key_ext[KEY_FIELD_W-1:0];
      out_stat_r <= res_stat_r;
      out_cnt_r  <= cnt_ext[COUNT_FIELD_W-1:0];
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.removed_key = out_key_r;
  assign out_if.status      = out_stat_r;
  assign out_if.entry_count = out_cnt_r;

  // checks
  `MHPQ_ASSERT_NOW(a_count_bound, 1'b1, count_z <= CAP_Z,
    "held count above capacity")
  `MHPQ_ASSERT_NEXT(a_insert_grows, in_fire && in_if.mode == MODE_INSERT && count_z != CAP_Z,
    count_r == $past(count_r) + 1'b1, "accepted insert did not grow the count")
  `MHPQ_ASSERT_NOW(a_descend_in_range, state_r == S_DN_CMP, lc <= count_z,
    "sift-down step without a held left child")
  `MHPQ_ASSERT_NOW(a_result_from_done, out_load, state_r == S_DONE && res_stat_r <= STAT_FULL,
    "result loaded outside the final step")

endmodule

`default_nettype wire

FILE: hdl/mhpq_store.sv
// key storage: one write port, two registered read ports
`default_nettype none

module mhpq_store #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 32,
  parameter int AW    = 7
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr_a,
  input  wire logic [AW-1:0]    raddr_b,
  output logic      [WIDTH-1:0] rdata_a,
  output logic      [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read ports, registered
  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire
